// ----- design/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared widths, codes and types of the direct-mapped cache lookup block.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int ADDR_W      = 32;
	localparam int WORD_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int LINE_BYTES  = 4;
	localparam int OFFSET_W    = $clog2(LINE_BYTES);
	localparam int SET_COUNT   = 16;
	localparam int SET_W       = $clog2(SET_COUNT);
	localparam int TAG_W       = ADDR_W - OFFSET_W - SET_W;
	localparam int STATUS_W    = 2;

	// decoupling queue between front and back; depth is a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_WRITE_DONE   = 2'd0,
		ST_READ_HIT     = 2'd1,
		ST_MISS_INVALID = 2'd2,
		ST_MISS_TAG     = 2'd3
	} status_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_READ  = 1'b1
	} mode_t;

	// classified access as handed from front to back
	typedef struct packed {
		mode_t               mode;
		logic [SET_W-1:0]    set_index;
		logic [TAG_W-1:0]    tag;
		logic [OFFSET_W-1:0] offset;
		logic [WORD_W-1:0]   write_word;
	} access_t;

endpackage

// ----- design/dmc_if.sv -----
// ----------------------------------------------------------------------------
// dmc_if
// Valid/ready channels of the cache lookup block: request and response.
// ----------------------------------------------------------------------------
interface dmc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [dmc_pkg::ADDR_W-1:0] address;
	logic [dmc_pkg::WORD_W-1:0] write_word;

	modport source(output valid, mode, address, write_word, input ready);
	modport sink(input valid, mode, address, write_word, output ready);
endinterface

interface dmc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dmc_pkg::SET_W-1:0]    set_index;
	logic [dmc_pkg::STATUS_W-1:0] status;
	logic                         line_was_valid;
	logic [dmc_pkg::TAG_W-1:0]    stored_tag;
	logic [dmc_pkg::WORD_W-1:0]   stored_word;
	logic [dmc_pkg::BYTE_W-1:0]   read_byte;

	modport source(output valid, set_index, status, line_was_valid, stored_tag,
		stored_word, read_byte, input ready);
	modport sink(input valid, set_index, status, line_was_valid, stored_tag,
		stored_word, read_byte, output ready);
endinterface

// ----- design/dmc_front.sv -----
// ----------------------------------------------------------------------------
// dmc_front
// Accepts request transactions, splits the address into tag, set and offset
// and queues the classified access for the back end.
// ----------------------------------------------------------------------------
module dmc_front (
	input  logic             clk,
	input  logic             arst_n,
	dmc_req_if.sink          req,
	output logic             acc_valid,
	input  logic             acc_ready,
	output dmc_pkg::access_t acc
);

	dmc_pkg::access_t                   queue_q [dmc_pkg::QUEUE_DEPTH];
	logic [dmc_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [dmc_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [dmc_pkg::QCNT_W-1:0]         count_q;
	dmc_pkg::access_t                   decoded;
	logic                               push;
	logic                               pop;

	always_comb begin
		decoded.mode       = dmc_pkg::mode_t'(req.mode);
		decoded.offset     = req.address[dmc_pkg::OFFSET_W-1:0];
		decoded.set_index  = req.address[dmc_pkg::OFFSET_W +: dmc_pkg::SET_W];
		decoded.tag        = req.address[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
		decoded.write_word = req.write_word;
	end

	assign req.ready = (count_q != dmc_pkg::QCNT_W'(dmc_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign acc_valid = (count_q != '0);
	assign pop       = acc_valid && acc_ready;
	assign acc       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

endmodule

// ----- design/dmc_back.sv -----
// ----------------------------------------------------------------------------
// dmc_back
// Carries out queued accesses against the line store: tag compare, byte
// select, line fill on writes, and the registered response.
// ----------------------------------------------------------------------------
module dmc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc_valid,
	output logic             acc_ready,
	input  dmc_pkg::access_t acc,
	dmc_rsp_if.source        rsp
);

	logic [dmc_pkg::SET_COUNT-1:0]  line_valid_q;
	logic [dmc_pkg::TAG_W-1:0]      line_tag_q  [dmc_pkg::SET_COUNT];
	logic [dmc_pkg::WORD_W-1:0]     line_data_q [dmc_pkg::SET_COUNT];

	logic                           rsp_valid_q;
	logic [dmc_pkg::SET_W-1:0]      rsp_set_q;
	dmc_pkg::status_t               rsp_status_q;
	logic                           rsp_was_valid_q;
	logic [dmc_pkg::TAG_W-1:0]      rsp_tag_q;
	logic [dmc_pkg::WORD_W-1:0]     rsp_word_q;
	logic [dmc_pkg::BYTE_W-1:0]     rsp_byte_q;

	logic                           advance;
	logic                           hit_valid;
	logic [dmc_pkg::TAG_W-1:0]      hit_tag;
	logic [dmc_pkg::WORD_W-1:0]     hit_data;
	dmc_pkg::status_t               nxt_status;
	logic [dmc_pkg::TAG_W-1:0]      nxt_tag;
	logic [dmc_pkg::WORD_W-1:0]     nxt_word;
	logic [dmc_pkg::BYTE_W-1:0]     nxt_byte;
	logic                           is_write;

	assign acc_ready = !rsp_valid_q || rsp.ready;
	assign advance   = acc_valid && acc_ready;
	assign is_write  = (acc.mode == dmc_pkg::MODE_WRITE);

	always_comb begin
		hit_valid  = line_valid_q[acc.set_index];
		hit_tag    = line_tag_q[acc.set_index];
		hit_data   = line_data_q[acc.set_index];
		// tag and data of an invalid line are never shown
		nxt_tag    = hit_valid ? hit_tag : '0;
		nxt_word   = '0;
		nxt_byte   = '0;
		if (is_write) begin
			nxt_status = dmc_pkg::ST_WRITE_DONE;
			if (hit_valid) begin
				nxt_word = hit_data;
			end
		end else if (!hit_valid) begin
			nxt_status = dmc_pkg::ST_MISS_INVALID;
		end else begin
			// byte comes back on a tag mismatch too
			nxt_byte   = hit_data[{acc.offset, 3'b000} +: dmc_pkg::BYTE_W];
			nxt_status = (hit_tag == acc.tag) ? dmc_pkg::ST_READ_HIT
				: dmc_pkg::ST_MISS_TAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			line_valid_q <= '0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (advance && is_write) begin
				line_valid_q[acc.set_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_set_q       <= acc.set_index;
			rsp_status_q    <= nxt_status;
			rsp_was_valid_q <= hit_valid;
			rsp_tag_q       <= nxt_tag;
			rsp_word_q      <= nxt_word;
			rsp_byte_q      <= nxt_byte;
			if (is_write) begin
				line_tag_q[acc.set_index]  <= acc.tag;
				line_data_q[acc.set_index] <= acc.write_word;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.set_index      = rsp_set_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.line_was_valid = rsp_was_valid_q;
	assign rsp.stored_tag     = rsp_tag_q;
	assign rsp.stored_word    = rsp_word_q;
	assign rsp.read_byte      = rsp_byte_q;

endmodule

// ----- design/direct_mapped_cache_lookup.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup
// Direct-mapped cache of 16 sets with 4-byte lines: line fill and byte read.
// ----------------------------------------------------------------------------
// Use: the request channel (req) carries mode, address and write_word. Mode
// write fills the whole line of the addressed set and reports the evicted
// line; mode read reports hit, miss on an invalid line or miss on a tag
// mismatch, with the stored tag and addressed byte of a valid line. Every
// request transaction gives exactly one response transaction on rsp, in order.
// A request is registered in the queue and then in the back end's response
// register. Throughput: one transaction per cycle while rsp is not stalled,
// set by the combinational store lookup and tag compare in the back end;
// the store is held in flip-flops.
// Reset clears all line valid bits at once, the two-entry queue and the
// response register; tag and data contents are not cleared.
// When the receiver stalls, the response register holds, the queue between
// front and back fills, and req.ready drops once it is full, so up to three
// transactions may be in flight.
// ----------------------------------------------------------------------------
module direct_mapped_cache_lookup (
	input  logic       clk,
	input  logic       arst_n,
	dmc_req_if.sink    req,
	dmc_rsp_if.source  rsp
);

	logic             acc_valid;
	logic             acc_ready;
	dmc_pkg::access_t acc;

	dmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc       (acc)
	);

	dmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc       (acc),
		.rsp       (rsp)
	);

endmodule

// ----- design/dmc_checker.sv -----
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module dmc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [dmc_pkg::STATUS_W-1:0] rsp_status,
	input logic                         rsp_was_valid,
	input logic [dmc_pkg::TAG_W-1:0]    rsp_tag,
	input logic [dmc_pkg::WORD_W-1:0]   rsp_word,
	input logic [dmc_pkg::BYTE_W-1:0]   rsp_byte
);

	// a stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// a miss on an invalid line shows nothing of the line
	a_miss_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == dmc_pkg::ST_MISS_INVALID) |->
		!rsp_was_valid && (rsp_tag == '0) && (rsp_byte == '0) && (rsp_word == '0))
		else $error("invalid-line miss carries line contents");

	// reads that found a line report it valid and never an evicted word
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == dmc_pkg::ST_READ_HIT ||
			rsp_status == dmc_pkg::ST_MISS_TAG) |->
		rsp_was_valid && (rsp_word == '0))
		else $error("read of a valid line reported wrongly");

	// a fill into an empty line evicts nothing
	a_write_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == dmc_pkg::ST_WRITE_DONE) && !rsp_was_valid |->
		(rsp_tag == '0) && (rsp_word == '0) && (rsp_byte == '0))
		else $error("fill of an empty line reports an eviction");

endmodule

bind direct_mapped_cache_lookup dmc_checker u_dmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_was_valid (rsp.line_was_valid),
	.rsp_tag       (rsp.stored_tag),
	.rsp_word      (rsp.stored_word),
	.rsp_byte      (rsp.read_byte)
);
